// ===== rtl/mbp_pkg.sv =====
// shared constants and types for the backpropagation perceptron
package mbp_pkg;

   localparam int FEATS                 = 4;
   localparam int HIDDEN_UNITS_DEF      = 5;
   localparam int OUTPUT_UNITS_DEF      = 3;
   localparam int SIGMOID_TABLE_DEPTH_DEF = 1024;

   localparam int OP_W    = 2;
   localparam int Q_W     = 24;
   localparam int ACT_W   = 17;
   localparam int LR_W    = 16;
   localparam int TC_W    = 2;
   localparam int PI_W    = 6;
   localparam int CLS_W   = 3;
   localparam int MUL_W   = 28;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = PROD_W;
   localparam int SIG_IN_W = 41;

   localparam logic [LR_W-1:0]  LR_RESET = 16'd6554;
   localparam logic [ACT_W-1:0] ACT_ONE  = 17'h10000;
   localparam logic [ACT_W-1:0] ACT_HALF = 17'h08000;

   typedef enum logic [OP_W-1:0] {
      OP_TRAIN = 2'd0,
      OP_INFER = 2'd1,
      OP_WRITE = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

endpackage

// ===== rtl/mbp_req_if.sv =====
// request channel: one sample or parameter write per transaction
interface mbp_req_if;
   logic                           valid;
   logic                           ready;
   logic [mbp_pkg::OP_W-1:0]       op;
   logic signed [mbp_pkg::Q_W-1:0] feature_a;
   logic signed [mbp_pkg::Q_W-1:0] feature_b;
   logic signed [mbp_pkg::Q_W-1:0] feature_c;
   logic signed [mbp_pkg::Q_W-1:0] feature_d;
   logic [mbp_pkg::TC_W-1:0]       target_class;
   logic [mbp_pkg::PI_W-1:0]       param_index;
   logic signed [mbp_pkg::Q_W-1:0] param_value;

   modport source (output valid, op, feature_a, feature_b, feature_c, feature_d,
                   target_class, param_index, param_value, input ready);
   modport sink   (input valid, op, feature_a, feature_b, feature_c, feature_d,
                   target_class, param_index, param_value, output ready);
endinterface

// ===== rtl/mbp_rsp_if.sv =====
// response channel: output activations and class bits per transaction
interface mbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mbp_pkg::ACT_W-1:0]   act_zero;
   logic [mbp_pkg::ACT_W-1:0]   act_one;
   logic [mbp_pkg::ACT_W-1:0]   act_two;
   logic [mbp_pkg::CLS_W-1:0]   class_bits;

   modport source (output valid, act_zero, act_one, act_two, class_bits, input ready);
   modport sink   (input valid, act_zero, act_one, act_two, class_bits, output ready);
endinterface

// ===== rtl/mbp_sigmoid.sv =====
// sigmoid lookup: table built at elaboration, registered rom read
module mbp_sigmoid #(
   parameter int DEPTH = mbp_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic signed [mbp_pkg::SIG_IN_W-1:0]  s_in,
   output logic [mbp_pkg::ACT_W-1:0]            act_out
);

   localparam int IW  = $clog2(DEPTH);
   localparam int OFW = 21;
   localparam int SCW = OFW + IW + 1;
   localparam logic signed [mbp_pkg::SIG_IN_W-1:0] LIM = mbp_pkg::SIG_IN_W'(1 << 20);
   // 2.71 in Q8.24
   localparam logic [63:0] ROOT0 = (64'd271 << 24) / 64'd100;

   typedef logic [mbp_pkg::ACT_W-1:0] tab_type [DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // shift-subtract quotient, only used while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = 64'd0;
      rem = 65'd0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         rem = {rem[63:0], a[bit_pos]};
         if (rem >= {1'b0, b}) begin
            rem = rem - {1'b0, b};
            quo[bit_pos] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] qmul(input logic [63:0] p, input logic [63:0] r);
      return (p >> 24) * r + (((p & 64'hFF_FFFF) * r) >> 24);
   endfunction

   function automatic tab_type build_tab();
      tab_type     t;
      logic [63:0] roots [17];
      logic [63:0] base;
      logic [63:0] at;
      logic [63:0] num;
      logic [63:0] n;
      logic [63:0] rem;
      logic [63:0] fb;
      logic [63:0] p;
      logic [63:0] q;
      logic        neg;
      roots[0] = ROOT0;
      for (int m = 1; m <= 16; m++) roots[m] = isqrt64(roots[m-1] << 24);
      base = 64'd16 * 64'(DEPTH);
      for (int i = 0; i < DEPTH; i++) begin
         at  = 64'd32 * 64'(i);
         neg = (at <= base);
         num = neg ? base - at : at - base;
         n   = udiv64(num, 64'(DEPTH));
         rem = num - n * 64'(DEPTH);
         fb  = udiv64(rem << 16, 64'(DEPTH));
         p   = 64'd1 << 24;
         for (longint c = 0; c < longint'(n); c++) p = qmul(p, roots[0]);
         for (int m = 1; m <= 16; m++)
            if (fb[16-m]) p = qmul(p, roots[m]);
         q = (64'd1 << 24) + p;
         if (neg) t[i] = mbp_pkg::ACT_W'(udiv64((64'd1 << 40) + (q >> 1), q));
         else     t[i] = mbp_pkg::ACT_W'(udiv64((p << 16) + (q >> 1), q));
      end
      return t;
   endfunction

   localparam tab_type TAB = build_tab();

   logic [OFW-1:0] off;
   logic [SCW-1:0] scaled;
   logic [IW-1:0]  idx;

   always_comb begin
      off    = s_in[OFW-1:0] + OFW'(1 << 20);
      scaled = SCW'(off) * SCW'(DEPTH);
      if (s_in < -LIM)      idx = '0;
      else if (s_in >= LIM) idx = IW'(DEPTH - 1);
      else                  idx = scaled[OFW +: IW];
   end

   always_ff @(posedge clock) begin
      act_out <= TAB[idx];
   end

endmodule

// ===== rtl/mlp_backprop_training_step.sv =====
// 4-h-o sigmoid perceptron with online backpropagation on one shared multiplier
//
//  channel   dir  handshake             moves
//  req_chan  in   valid/ready           op, features, target, parameter write
//  rsp_chan  out  valid/ready           three activations, class bits
//  csr_*     in   write enable          learning rate
//
// every multiply step runs through parameter ram read, registered multiply,
// then accumulate or write back. infer runs the hidden and output layers, train
// adds the backward pass and weight updates; a write completes in the idle state.
// synchronous reset clears control and loads the default learning rate; parameters are undefined until written.
// req_chan is ready only when idle and the response slot is free or draining.
module mlp_backprop_training_step #(
   parameter int HIDDEN_UNITS        = mbp_pkg::HIDDEN_UNITS_DEF,
   parameter int OUTPUT_UNITS        = mbp_pkg::OUTPUT_UNITS_DEF,
   parameter int SIGMOID_TABLE_DEPTH = mbp_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   mbp_req_if.sink                    req_chan,
   mbp_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [mbp_pkg::LR_W-1:0]   csr_write_data
);

   localparam int H          = HIDDEN_UNITS;
   localparam int O          = OUTPUT_UNITS;
   localparam int F          = mbp_pkg::FEATS;
   localparam int WW_BASE    = F * H;
   localparam int TH_BASE    = WW_BASE + H * O;
   localparam int THR_BASE   = TH_BASE + H;
   localparam int NUM_PARAMS = THR_BASE + O;
   localparam int PAW        = $clog2(NUM_PARAMS);
   localparam int JW         = (H > 1) ? $clog2(H) : 1;
   localparam int KW         = (O > 1) ? $clog2(O) : 1;
   localparam int QW         = mbp_pkg::Q_W;
   localparam int AW         = mbp_pkg::ACT_W;
   localparam int MW         = mbp_pkg::MUL_W;
   localparam int PW         = mbp_pkg::PROD_W;
   localparam int CW         = mbp_pkg::ACC_W;
   localparam int SW         = mbp_pkg::SIG_IN_W;

   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_UPD  = 2'd2;

   typedef enum logic [16:0] {
      S_IDLE  = 17'b00000000000000001,
      S_HSUM  = 17'b00000000000000010,
      S_HTH   = 17'b00000000000000100,
      S_OSUM  = 17'b00000000000001000,
      S_OTH   = 17'b00000000000010000,
      S_DY1   = 17'b00000000000100000,
      S_DY2   = 17'b00000000001000000,
      S_DTHR  = 17'b00000000010000000,
      S_DDSUM = 17'b00000000100000000,
      S_DD1   = 17'b00000001000000000,
      S_DD2   = 17'b00000010000000000,
      S_LH    = 17'b00000100000000000,
      S_WW    = 17'b00001000000000000,
      S_TH    = 17'b00010000000000000,
      S_LX    = 17'b00100000000000000,
      S_W     = 17'b01000000000000000,
      S_FIN   = 17'b10000000000000000
   } state_type;

   function automatic logic signed [QW-1:0] sat_q(input logic signed [CW-1:0] v);
      if (v > CW'(signed'(24'sh7F_FFFF)))  return 24'sh7F_FFFF;
      if (v < CW'(signed'(-24'sh80_0000))) return -24'sh80_0000;
      return QW'(v);
   endfunction

   state_type              state_ff, state_in;
   logic [1:0]             ph_ff, ph_in;
   logic [1:0]             i_ff, i_in;
   logic [JW-1:0]          j_ff, j_in;
   logic [KW-1:0]          k_ff, k_in;
   logic signed [CW-1:0]   acc_ff, acc_in;
   logic signed [MW-1:0]   t1_ff, t1_in;
   logic signed [PW-1:0]   prod_ff;
   logic                   train_ff;
   logic [mbp_pkg::TC_W-1:0] tc_ff;
   logic [mbp_pkg::LR_W-1:0] lr_ff;

   logic signed [QW-1:0]   x_ff  [F];
   logic signed [QW-1:0]   lx_ff [F];
   logic [AW-1:0]          hy_ff [H];
   logic [AW-1:0]          y_ff  [O];
   logic signed [MW-1:0]   d_ff  [O];
   logic signed [MW-1:0]   dd_ff [H];

   logic [QW-1:0]          pm_mem [NUM_PARAMS];
   logic [QW-1:0]          mem_q_ff;
   logic [PAW-1:0]         rd_addr;
   logic                   mem_we;
   logic [PAW-1:0]         mem_wa;
   logic [QW-1:0]          mem_wd;

   logic                   rsp_valid_ff;
   logic [AW-1:0]          act_ff [3];
   logic [mbp_pkg::CLS_W-1:0] class_ff;
   logic                   rsp_load, rsp_zero;

   logic                   hy_we, y_we, d_we, dd_we, lx_we;
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [QW-1:0]   mem_q_s;
   logic signed [PW-1:0]   prod_sh;
   logic signed [CW-1:0]   acc_sh;
   logic signed [SW-1:0]   s_sel;
   logic [AW-1:0]          sig_q;
   logic signed [CW-1:0]   upd_add, upd_sub;
   logic signed [MW-1:0]   tgt;
   logic                   slot_free, req_take, ph_last;
   logic                   i_last, j_last, k_last;
   logic [AW-1:0]          act_sel [3];
   logic [mbp_pkg::CLS_W-1:0] cls_sel;

   mbp_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sigmoid (
      .clock   (clock),
      .s_in    (s_sel),
      .act_out (sig_q)
   );

   for (genvar g = 0; g < 3; g++) begin : g_act
      if (g < O) begin : g_on
         assign act_sel[g] = y_ff[g];
      end else begin : g_off
         assign act_sel[g] = '0;
      end
      assign cls_sel[g] = (act_sel[g] > mbp_pkg::ACT_HALF);
   end

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.act_zero   = act_ff[0];
   assign rsp_chan.act_one    = act_ff[1];
   assign rsp_chan.act_two    = act_ff[2];
   assign rsp_chan.class_bits = class_ff;

   assign mem_q_s = signed'(mem_q_ff);
   assign prod_sh = prod_ff >>> 16;
   assign acc_sh  = acc_ff >>> 16;
   assign s_sel   = SW'(acc_sh) - SW'(mem_q_s);
   assign upd_add = CW'(mem_q_s) + CW'(prod_sh);
   assign upd_sub = CW'(mem_q_s) - CW'(prod_sh);
   assign tgt     = (int'(k_ff) == int'(tc_ff)) ? MW'(mbp_pkg::ACT_ONE) : '0;
   assign ph_last = (ph_ff == PH_UPD);
   assign i_last  = (i_ff == 2'(F - 1));
   assign j_last  = (j_ff == JW'(H - 1));
   assign k_last  = (k_ff == KW'(O - 1));

   // address and multiplier operands per step
   always_comb begin
      rd_addr = '0;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_HSUM: begin
            rd_addr = PAW'(int'(i_ff) * H + int'(j_ff));
            mul_a   = MW'(mem_q_s);
            mul_b   = MW'(x_ff[i_ff]);
         end
         S_HTH: rd_addr = PAW'(TH_BASE + int'(j_ff));
         S_OSUM: begin
            rd_addr = PAW'(WW_BASE + int'(j_ff) * O + int'(k_ff));
            mul_a   = MW'(mem_q_s);
            mul_b   = MW'(hy_ff[j_ff]);
         end
         S_OTH: rd_addr = PAW'(THR_BASE + int'(k_ff));
         S_DY1: begin
            mul_a = MW'(y_ff[k_ff]);
            mul_b = MW'(mbp_pkg::ACT_ONE) - MW'(y_ff[k_ff]);
         end
         S_DY2: begin
            mul_a = t1_ff;
            mul_b = tgt - MW'(y_ff[k_ff]);
         end
         S_DTHR: begin
            rd_addr = PAW'(THR_BASE + int'(k_ff));
            mul_a   = MW'(lr_ff);
            mul_b   = d_ff[k_ff];
         end
         S_DDSUM: begin
            rd_addr = PAW'(WW_BASE + int'(j_ff) * O + int'(k_ff));
            mul_a   = d_ff[k_ff];
            mul_b   = MW'(mem_q_s);
         end
         S_DD1: begin
            mul_a = MW'(hy_ff[j_ff]);
            mul_b = MW'(mbp_pkg::ACT_ONE) - MW'(hy_ff[j_ff]);
         end
         S_DD2: begin
            mul_a = t1_ff;
            mul_b = MW'(acc_sh);
         end
         S_LH: begin
            mul_a = MW'(lr_ff);
            mul_b = MW'(hy_ff[j_ff]);
         end
         S_WW: begin
            rd_addr = PAW'(WW_BASE + int'(j_ff) * O + int'(k_ff));
            mul_a   = t1_ff;
            mul_b   = d_ff[k_ff];
         end
         S_TH: begin
            rd_addr = PAW'(TH_BASE + int'(j_ff));
            mul_a   = MW'(lr_ff);
            mul_b   = dd_ff[j_ff];
         end
         S_LX: begin
            mul_a = MW'(lr_ff);
            mul_b = MW'(x_ff[i_ff]);
         end
         S_W: begin
            rd_addr = PAW'(int'(i_ff) * H + int'(j_ff));
            mul_a   = MW'(lx_ff[i_ff]);
            mul_b   = dd_ff[j_ff];
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      t1_in    = t1_ff;
      hy_we    = 1'b0;
      y_we     = 1'b0;
      d_we     = 1'b0;
      dd_we    = 1'b0;
      lx_we    = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = rd_addr;
      mem_wd   = sat_q(upd_add);
      rsp_load = 1'b0;
      rsp_zero = 1'b0;

      if (state_ff != S_IDLE && state_ff != S_FIN)
         ph_in = ph_last ? PH_ADDR : ph_ff + 2'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_chan.op == mbp_pkg::OP_WRITE) begin
                  mem_we   = (int'(req_chan.param_index) < NUM_PARAMS);
                  mem_wa   = PAW'(req_chan.param_index);
                  mem_wd   = req_chan.param_value;
                  rsp_load = 1'b1;
                  rsp_zero = 1'b1;
               end else begin
                  state_in = S_HSUM;
                  ph_in    = PH_ADDR;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  acc_in   = '0;
               end
            end
         end
         S_HSUM: if (ph_last) begin
            acc_in = acc_ff + CW'(prod_ff);
            if (i_last) begin
               i_in     = '0;
               state_in = S_HTH;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         S_HTH: if (ph_last) begin
            hy_we  = 1'b1;
            acc_in = '0;
            if (j_last) begin
               j_in     = '0;
               k_in     = '0;
               state_in = S_OSUM;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = S_HSUM;
            end
         end
         S_OSUM: if (ph_last) begin
            acc_in = acc_ff + CW'(prod_ff);
            if (j_last) begin
               j_in     = '0;
               state_in = S_OTH;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         S_OTH: if (ph_last) begin
            y_we   = 1'b1;
            acc_in = '0;
            if (k_last) begin
               k_in     = '0;
               state_in = train_ff ? S_DY1 : S_FIN;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_OSUM;
            end
         end
         S_DY1: if (ph_last) begin
            t1_in    = MW'(prod_sh);
            state_in = S_DY2;
         end
         S_DY2: if (ph_last) begin
            d_we     = 1'b1;
            state_in = S_DTHR;
         end
         S_DTHR: if (ph_last) begin
            mem_we = 1'b1;
            mem_wd = sat_q(upd_sub);
            if (k_last) begin
               k_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               state_in = S_DDSUM;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_DY1;
            end
         end
         S_DDSUM: if (ph_last) begin
            acc_in = acc_ff + CW'(prod_ff);
            if (k_last) begin
               k_in     = '0;
               state_in = S_DD1;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_DD1: if (ph_last) begin
            t1_in    = MW'(prod_sh);
            state_in = S_DD2;
         end
         S_DD2: if (ph_last) begin
            dd_we  = 1'b1;
            acc_in = '0;
            if (j_last) begin
               j_in     = '0;
               state_in = S_LH;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = S_DDSUM;
            end
         end
         S_LH: if (ph_last) begin
            t1_in    = MW'(prod_sh);
            k_in     = '0;
            state_in = S_WW;
         end
         S_WW: if (ph_last) begin
            mem_we = 1'b1;
            if (k_last) begin
               k_in     = '0;
               state_in = S_TH;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_TH: if (ph_last) begin
            mem_we = 1'b1;
            mem_wd = sat_q(upd_sub);
            if (j_last) begin
               j_in     = '0;
               i_in     = '0;
               state_in = S_LX;
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = S_LH;
            end
         end
         S_LX: if (ph_last) begin
            lx_we = 1'b1;
            if (i_last) begin
               i_in     = '0;
               j_in     = '0;
               state_in = S_W;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         S_W: if (ph_last) begin
            mem_we = 1'b1;
            if (i_last) begin
               i_in = '0;
               if (j_last) begin
                  j_in     = '0;
                  state_in = S_FIN;
               end else begin
                  j_in = j_ff + JW'(1);
               end
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_ADDR;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= mbp_pkg::LR_RESET;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         if (rsp_load)            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if (csr_write_enable)    lr_ff <= csr_write_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      t1_ff   <= t1_in;
      prod_ff <= mul_a * mul_b;
      if (req_take) begin
         x_ff[0]  <= req_chan.feature_a;
         x_ff[1]  <= req_chan.feature_b;
         x_ff[2]  <= req_chan.feature_c;
         x_ff[3]  <= req_chan.feature_d;
         tc_ff    <= req_chan.target_class;
         train_ff <= (req_chan.op == mbp_pkg::OP_TRAIN);
      end
      if (hy_we) hy_ff[j_ff] <= sig_q;
      if (y_we)  y_ff[k_ff]  <= sig_q;
      if (d_we)  d_ff[k_ff]  <= MW'(prod_sh);
      if (dd_we) dd_ff[j_ff] <= MW'(prod_sh);
      if (lx_we) lx_ff[i_ff] <= QW'(prod_sh);
      if (rsp_load) begin
         for (int n = 0; n < 3; n++) act_ff[n] <= rsp_zero ? '0 : act_sel[n];
         class_ff <= rsp_zero ? '0 : cls_sel;
      end
   end

   // parameter ram, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) pm_mem[mem_wa] <= mem_wd;
      mem_q_ff <= pm_mem[rd_addr];
   end

endmodule
